[rtl/color_adjust_pixel_pipeline_assert.svh]
// assertion macros for the colour adjust checker
`ifndef COLOR_ADJUST_PIXEL_PIPELINE_ASSERT_SVH
`define COLOR_ADJUST_PIXEL_PIPELINE_ASSERT_SVH

// same-cycle implication
`define CADJ_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("colour adjust check failed");

// next-cycle implication
`define CADJ_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("colour adjust check failed");

`endif

[rtl/cadj_pkg.sv]
// shared constants, types and divider helpers for the colour adjust pipeline
package cadj_pkg;

	localparam int FRAC_BITS = 16;
	localparam int ONE_FX    = 1 << FRAC_BITS;

	// register indexes of the configuration port
	localparam logic [3:0] CFG_TINT_RED   = 4'd0;
	localparam logic [3:0] CFG_TINT_GREEN = 4'd1;
	localparam logic [3:0] CFG_TINT_BLUE  = 4'd2;
	localparam logic [3:0] CFG_BLEND_PCT  = 4'd3;
	localparam logic [3:0] CFG_ADJ_EN     = 4'd4;
	localparam logic [3:0] CFG_BRIGHT     = 4'd5;
	localparam logic [3:0] CFG_SATURATION = 4'd6;
	localparam logic [3:0] CFG_CONTRAST   = 4'd7;

	// reciprocal of 100 scaled by 2^24, rounded up; exact for the blend range
	localparam int BLEND_SHIFT = 24;
	localparam int BLEND_MUL   = ((1 << BLEND_SHIFT) + 99) / 100;

	// contrast factor for c = 0 and the contrast offset
	localparam int FACTOR_RESET  = (256 * ONE_FX) / 257;
	localparam int CONTRAST_BIAS = 255 * ONE_FX;
	localparam int FACTOR_STEPS  = 25;

	// hue and saturation divider state
	typedef struct packed {
		logic [16:0] quo;
		logic [7:0]  rem;
	} div_t;

	// leading quotient bit of (n << 16) / dv, n <= dv
	function automatic div_t div_init(input logic [7:0] n, input logic [7:0] dv);
		div_t y;
		y.quo = {16'b0, n >= dv};
		y.rem = (n >= dv) ? 8'(n - dv) : n;
		return y;
	endfunction

	// four restoring division steps
	function automatic div_t div4(input div_t x, input logic [7:0] dv);
		div_t       y;
		logic [8:0] r2;
		y = x;
		for (int i = 0; i < 4; i++) begin
			r2 = {y.rem, 1'b0};
			if (r2 >= {1'b0, dv}) begin
				y.rem = 8'(r2 - {1'b0, dv});
				y.quo = {y.quo[15:0], 1'b1};
			end else begin
				y.rem = r2[7:0];
				y.quo = {y.quo[15:0], 1'b0};
			end
		end
		return y;
	endfunction

endpackage

[rtl/color_adjust_pixel_pipeline.sv]
// colour adjust pipeline: tint blend, brightness, saturation and contrast
//
//  channel  | direction | contents
//  s_axis   | in        | tdata: red_in, green_in, blue_in
//  m_axis   | out       | tdata: red_out, green_out, blue_out
//  cfg      | in        | cfg_index selects a register, cfg_data its value
//
// fifteen register stages; one pixel per clock while the output is taken and
// no contrast divide runs. A contrast write runs a serial divider for the
// contrast factor; pixels and further writes wait until it is done.
// arst_n clears the valid bits and configuration registers and loads the
// c = 0 contrast factor; stalls hold each full stage whose successor cannot
// advance, and empty stages keep filling.
module color_adjust_pixel_pipeline (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // red_in, green_in, blue_in
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // red_out, green_out, blue_out
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [9:0]  cfg_data
);
	import cadj_pkg::*;

	localparam int NSTG = 15;

	// configuration registers
	logic [7:0]        tint_r_q, tint_g_q, tint_b_q;
	logic [6:0]        pct_q;
	logic              adj_en_q;
	logic signed [8:0] bright_q;
	logic signed [9:0] sat_adj_q;
	logic [23:0]       factor_q;

	// contrast factor divider
	logic              busy_q;
	logic [4:0]        cnt_q;
	logic [24:0]       dvd_q;
	logic [9:0]        rem_q;
	logic [9:0]        dvs_q;
	logic [10:0]       fr2;
	logic              fbit;
	logic [9:0]        frem_next;
	logic              cfg_acc;

	assign cfg_ready = !busy_q;
	assign cfg_acc   = cfg_valid && cfg_ready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tint_r_q  <= '0;
			tint_g_q  <= '0;
			tint_b_q  <= '0;
			pct_q     <= '0;
			adj_en_q  <= 1'b0;
			bright_q  <= '0;
			sat_adj_q <= '0;
		end else if (cfg_acc) begin
			case (cfg_index)
				CFG_TINT_RED:   tint_r_q  <= cfg_data[7:0];
				CFG_TINT_GREEN: tint_g_q  <= cfg_data[7:0];
				CFG_TINT_BLUE:  tint_b_q  <= cfg_data[7:0];
				CFG_BLEND_PCT:  pct_q     <= cfg_data[6:0];
				CFG_ADJ_EN:     adj_en_q  <= cfg_data[0];
				CFG_BRIGHT:     bright_q  <= $signed(cfg_data[8:0]);
				CFG_SATURATION: sat_adj_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// serial divide (c+256) << 16 by (257-c)
	assign fr2       = {rem_q, dvd_q[24]};
	assign fbit      = fr2 >= {1'b0, dvs_q};
	assign frem_next = fbit ? 10'(fr2 - {1'b0, dvs_q}) : fr2[9:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			cnt_q    <= '0;
			dvd_q    <= '0;
			rem_q    <= '0;
			dvs_q    <= '0;
			factor_q <= 24'(FACTOR_RESET);
		end else if (cfg_acc && cfg_index == CFG_CONTRAST) begin
			dvd_q  <= {cfg_data[8:0] ^ 9'h100, 16'b0};
			rem_q  <= '0;
			dvs_q  <= 10'd257 - {cfg_data[8], cfg_data[8:0]};
			cnt_q  <= 5'(FACTOR_STEPS);
			busy_q <= 1'b1;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[23:0], fbit};
			rem_q <= frem_next;
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1) begin
				busy_q   <= 1'b0;
				factor_q <= {dvd_q[22:0], fbit};
			end
		end
	end

	// stage valid bits and advance enables
	logic [NSTG:1] vld_q;
	logic [NSTG:1] en;
	logic          in_acc;

	always_comb begin
		en[NSTG] = !vld_q[NSTG] || m_axis_tready;
		for (int k = NSTG - 1; k >= 1; k--)
			en[k] = !vld_q[k] || en[k + 1];
	end

	assign s_axis_tready = en[1] && !busy_q;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = vld_q[NSTG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1])
				vld_q[1] <= in_acc;
			for (int k = 2; k <= NSTG; k++)
				if (en[k])
					vld_q[k] <= vld_q[k - 1];
		end
	end

	// per-channel helpers
	function automatic logic signed [17:0] blend_num(input logic [7:0] pix,
		input logic [7:0] tint, input logic [6:0] pct);
		logic signed [8:0] wp;
		wp = 9'sd100 - $signed({2'b0, pct});
		return $signed({1'b0, pix}) * wp + $signed({1'b0, tint}) * $signed({2'b0, pct});
	endfunction

	function automatic logic [7:0] blend_div(input logic signed [17:0] num);
		logic [33:0] prod;
		prod = {1'b0, num[15:0]} * 18'(BLEND_MUL);
		if (num[17])
			return 8'd0;
		else if (prod[33:BLEND_SHIFT] > 10'd255)
			return 8'd255;
		else
			return prod[BLEND_SHIFT+7:BLEND_SHIFT];
	endfunction

	function automatic logic [7:0] bright_add(input logic [7:0] v,
		input logic signed [8:0] b);
		logic signed [9:0] sum;
		sum = $signed({2'b0, v}) + b;
		if (sum < 10'sd1)
			return 8'd1;
		else if (sum > 10'sd255)
			return 8'd255;
		else
			return sum[7:0];
	endfunction

	function automatic logic signed [34:0] contrast_total(input logic [7:0] v,
		input logic [23:0] fac);
		logic signed [9:0] sv;
		sv = $signed({1'b0, v, 1'b0}) - 10'sd255;
		return sv * $signed({1'b0, fac}) + 35'(CONTRAST_BIAS);
	endfunction

	function automatic logic [7:0] contrast_out(input logic signed [34:0] tot);
		if (tot <= 35'sd0)
			return 8'd0;
		else if (tot[34:FRAC_BITS+1] > 18'd255)
			return 8'd255;
		else
			return tot[FRAC_BITS+8:FRAC_BITS+1];
	endfunction

	// stage 1: blend numerators
	logic signed [2:0][17:0] num_s1;
	always_ff @(posedge clk) begin
		if (en[1]) begin
			num_s1[0] <= blend_num(s_axis_tdata[7:0], tint_r_q, pct_q);
			num_s1[1] <= blend_num(s_axis_tdata[15:8], tint_g_q, pct_q);
			num_s1[2] <= blend_num(s_axis_tdata[23:16], tint_b_q, pct_q);
		end
	end

	// stage 2: divide by 100 and clamp
	logic [2:0][7:0] c_s2;
	always_ff @(posedge clk) begin
		if (en[2])
			for (int k = 0; k < 3; k++)
				c_s2[k] <= blend_div(num_s1[k]);
	end

	// stage 3: brightness offset while adjust is enabled
	logic [2:0][7:0] c_s3;
	always_ff @(posedge clk) begin
		if (en[3])
			for (int k = 0; k < 3; k++)
				c_s3[k] <= adj_en_q ? bright_add(c_s2[k], bright_q) : c_s2[k];
	end

	// stage 4: min, max, hue sector base and difference
	logic [7:0]        lo, hi;
	logic signed [8:0] f;
	logic [2:0]        base;
	logic [2:0][7:0]   c_s4;
	logic [7:0]        hi_s4, d_s4, fabs_s4;
	logic              fneg_s4, grey_s4;
	logic [2:0]        base_s4;

	always_comb begin
		lo = c_s3[0];
		hi = c_s3[0];
		if (c_s3[1] < lo) lo = c_s3[1];
		if (c_s3[2] < lo) lo = c_s3[2];
		if (c_s3[1] > hi) hi = c_s3[1];
		if (c_s3[2] > hi) hi = c_s3[2];
		if (c_s3[0] == lo) begin
			f    = $signed({1'b0, c_s3[1]}) - $signed({1'b0, c_s3[2]});
			base = 3'd3;
		end else if (c_s3[1] == lo) begin
			f    = $signed({1'b0, c_s3[2]}) - $signed({1'b0, c_s3[0]});
			base = 3'd5;
		end else begin
			f    = $signed({1'b0, c_s3[0]}) - $signed({1'b0, c_s3[1]});
			base = 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			c_s4    <= c_s3;
			hi_s4   <= hi;
			d_s4    <= hi - lo;
			fneg_s4 <= f[8];
			fabs_s4 <= f[8] ? 8'(-f) : f[7:0];
			base_s4 <= base;
			grey_s4 <= lo == hi;
		end
	end

	// stages 5 to 8: hue and saturation dividers
	logic [2:0][7:0] c_s5, c_s6, c_s7, c_s8;
	logic [7:0]      hi_s5, hi_s6, hi_s7, hi_s8;
	logic [7:0]      d_s5, d_s6, d_s7;
	logic [2:0]      base_s5, base_s6, base_s7, base_s8;
	logic            fneg_s5, fneg_s6, fneg_s7, fneg_s8;
	logic            grey_s5, grey_s6, grey_s7, grey_s8;
	div_t            hd_s5, hd_s6, hd_s7, hd_s8;
	div_t            sd_s5, sd_s6, sd_s7, sd_s8;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			c_s5 <= c_s4; hi_s5 <= hi_s4; d_s5 <= d_s4;
			base_s5 <= base_s4; fneg_s5 <= fneg_s4; grey_s5 <= grey_s4;
			hd_s5 <= div4(div_init(fabs_s4, d_s4), d_s4);
			sd_s5 <= div4(div_init(d_s4, hi_s4), hi_s4);
		end
		if (en[6]) begin
			c_s6 <= c_s5; hi_s6 <= hi_s5; d_s6 <= d_s5;
			base_s6 <= base_s5; fneg_s6 <= fneg_s5; grey_s6 <= grey_s5;
			hd_s6 <= div4(hd_s5, d_s5);
			sd_s6 <= div4(sd_s5, hi_s5);
		end
		if (en[7]) begin
			c_s7 <= c_s6; hi_s7 <= hi_s6; d_s7 <= d_s6;
			base_s7 <= base_s6; fneg_s7 <= fneg_s6; grey_s7 <= grey_s6;
			hd_s7 <= div4(hd_s6, d_s6);
			sd_s7 <= div4(sd_s6, hi_s6);
		end
		if (en[8]) begin
			c_s8 <= c_s7; hi_s8 <= hi_s7;
			base_s8 <= base_s7; fneg_s8 <= fneg_s7; grey_s8 <= grey_s7;
			hd_s8 <= div4(hd_s7, d_s7);
			sd_s8 <= div4(sd_s7, hi_s7);
		end
	end

	// stage 9: hue angle and saturation scaling product
	logic [18:0]  h_raw;
	logic         spos;
	logic [16:0]  smul;
	logic [9:0]   smag;
	logic [2:0][7:0] c_s9;
	logic [7:0]   hi_s9;
	logic         grey_s9, spos_s9;
	logic [18:0]  h_s9;
	logic [16:0]  sat_s9;
	logic [26:0]  prod_s9;

	always_comb begin
		h_raw = fneg_s8 ? (19'(base_s8) << FRAC_BITS) + 19'(hd_s8.quo)
		                : (19'(base_s8) << FRAC_BITS) - 19'(hd_s8.quo);
		if (h_raw >= 19'(6 * ONE_FX))
			h_raw = h_raw - 19'(6 * ONE_FX);
		spos = sat_adj_q > 10'sd0;
		smul = spos ? 17'(ONE_FX) - sd_s8.quo : sd_s8.quo;
		smag = spos ? sat_adj_q : 10'(-sat_adj_q);
	end

	always_ff @(posedge clk) begin
		if (en[9]) begin
			c_s9    <= c_s8;
			hi_s9   <= hi_s8;
			grey_s9 <= grey_s8;
			h_s9    <= h_raw;
			sat_s9  <= sd_s8.quo;
			spos_s9 <= spos;
			prod_s9 <= smul * smag;
		end
	end

	// stage 10: adjusted saturation, clamped to 0..one
	logic signed [19:0] sat_sum;
	logic [2:0][7:0] c_s10;
	logic [7:0]      hi_s10;
	logic            grey_s10;
	logic [16:0]     sat_s10;
	logic [2:0]      sect_s10;
	logic [15:0]     frac_s10;

	always_comb begin
		sat_sum = spos_s9 ? $signed({3'b0, sat_s9}) + $signed({1'b0, prod_s9[26:8]})
		                  : $signed({3'b0, sat_s9}) - $signed({1'b0, prod_s9[26:8]});
	end

	always_ff @(posedge clk) begin
		if (en[10]) begin
			c_s10    <= c_s9;
			hi_s10   <= hi_s9;
			grey_s10 <= grey_s9;
			sect_s10 <= h_s9[18:16];
			frac_s10 <= h_s9[15:0];
			if (sat_sum < 20'sd0)
				sat_s10 <= '0;
			else if (sat_sum > 20'sd65536)
				sat_s10 <= 17'(ONE_FX);
			else
				sat_s10 <= sat_sum[16:0];
		end
	end

	// stage 11: p and the two saturation-fraction products
	logic [24:0]     pful;
	logic [32:0]     sf1;
	logic [33:0]     sf2;
	logic [2:0][7:0] c_s11;
	logic [7:0]      hi_s11, p_s11;
	logic            grey_s11;
	logic [2:0]      sect_s11;
	logic [16:0]     sf1_s11, sf2_s11;

	always_comb begin
		pful = hi_s10 * (17'(ONE_FX) - sat_s10);
		sf1  = sat_s10 * frac_s10;
		sf2  = sat_s10 * (17'(ONE_FX) - {1'b0, frac_s10});
	end

	always_ff @(posedge clk) begin
		if (en[11]) begin
			c_s11    <= c_s10;
			hi_s11   <= hi_s10;
			grey_s11 <= grey_s10;
			sect_s11 <= sect_s10;
			p_s11    <= pful[23:16];
			sf1_s11  <= sf1[32:16];
			sf2_s11  <= sf2[32:16];
		end
	end

	// stage 12: q and t
	logic [24:0]     qful, tful;
	logic [2:0][7:0] c_s12;
	logic [7:0]      hi_s12, p_s12, q_s12, t_s12;
	logic            grey_s12;
	logic [2:0]      sect_s12;

	always_comb begin
		qful = hi_s11 * (17'(ONE_FX) - sf1_s11);
		tful = hi_s11 * (17'(ONE_FX) - sf2_s11);
	end

	always_ff @(posedge clk) begin
		if (en[12]) begin
			c_s12    <= c_s11;
			hi_s12   <= hi_s11;
			grey_s12 <= grey_s11;
			sect_s12 <= sect_s11;
			p_s12    <= p_s11;
			q_s12    <= qful[23:16];
			t_s12    <= tful[23:16];
		end
	end

	// stage 13: sector selection back to rgb
	logic [2:0][7:0] sel;
	logic [2:0][7:0] c_s13, col_s13;

	always_comb begin
		case (sect_s12)
			3'd0:    sel = {p_s12, t_s12, hi_s12};
			3'd1:    sel = {p_s12, hi_s12, q_s12};
			3'd2:    sel = {t_s12, hi_s12, p_s12};
			3'd3:    sel = {hi_s12, q_s12, p_s12};
			3'd4:    sel = {hi_s12, p_s12, t_s12};
			default: sel = {q_s12, p_s12, hi_s12};
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[13]) begin
			c_s13   <= c_s12;
			col_s13 <= grey_s12 ? c_s12 : sel;
		end
	end

	// stage 14: contrast sums
	logic [2:0][7:0]         c_s14;
	logic signed [2:0][34:0] tot_s14;
	always_ff @(posedge clk) begin
		if (en[14]) begin
			c_s14 <= c_s13;
			for (int k = 0; k < 3; k++)
				tot_s14[k] <= contrast_total(col_s13[k], factor_q);
		end
	end

	// stage 15: contrast clamp while adjust is enabled, output register
	logic [2:0][7:0] out_s15;
	always_ff @(posedge clk) begin
		if (en[15])
			for (int k = 0; k < 3; k++)
				out_s15[k] <= adj_en_q ? contrast_out(tot_s14[k]) : c_s14[k];
	end

	assign m_axis_tdata = out_s15;

endmodule

[rtl/cadj_checker.sv]
// port checker for the colour adjust pipeline, bound to the top level
`include "color_adjust_pixel_pipeline_assert.svh"

module cadj_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [23:0] s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [3:0]  cfg_index,
	input logic [9:0]  cfg_data
);
	import cadj_pkg::*;

	// no pixel is accepted while the contrast divider runs
	`CADJ_ASSERT_IMPLY(a_busy_blocks_pixels, clk, arst_n, !cfg_ready, !s_axis_tready)

	// a contrast write starts the divider
	`CADJ_ASSERT_NEXT(a_contrast_starts_div, clk, arst_n, cfg_valid && cfg_ready && cfg_index == CFG_CONTRAST, !cfg_ready)

	// other writes leave the port free
	`CADJ_ASSERT_NEXT(a_plain_write_free, clk, arst_n, cfg_valid && cfg_ready && cfg_index != CFG_CONTRAST, cfg_ready)

	// a stalled result holds
	`CADJ_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind color_adjust_pixel_pipeline cadj_checker u_cadj_checker (.*);

[test/testbench.sv]
// self-checking testbench for the color adjust pixel pipeline
`timescale 1ns / 1ps

module testbench;
	import cadj_pkg::*;

	localparam int CH_MAX   = 255;
	localparam longint ONE  = 64'sd1 << FRAC_BITS;
	localparam int DRAIN    = 60;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;  // red_in, green_in, blue_in
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;  // red_out, green_out, blue_out
	logic        cfg_valid;
	logic        cfg_ready;
	logic [3:0]  cfg_index;
	logic [9:0]  cfg_data;

	// register copy for the predictor
	logic [7:0] tint_r, tint_g, tint_b;
	logic [6:0] pct_reg;
	logic       adj_en;
	logic [8:0] bright_reg;
	logic [9:0] sat_reg;
	logic [8:0] contrast_reg;

	int  errors;
	bit  hold_off;

	color_adjust_pixel_pipeline dut (.*);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// integer tint blend per channel, truncating toward zero
	function automatic longint tint_mix(longint pix, longint tint);
		longint pct;
		pct = pct_reg;
		return clip((pix * (100 - pct) + tint * pct) / 100, 0, CH_MAX);
	endfunction

	// hsv round trip with scaled saturation
	function automatic void rescale_saturation(ref longint ch[3], input longint s);
		longint lo, hi, d, f, base, mag, hue, sector, frac, sat, p, q, t, sf;
		lo = ch[0]; hi = ch[0];
		for (int k = 1; k < 3; k++) begin
			if (ch[k] < lo) lo = ch[k];
			if (ch[k] > hi) hi = ch[k];
		end
		if (lo == hi || hi <= 0) return;
		d = hi - lo;
		if (ch[0] == lo) begin
			f = ch[1] - ch[2]; base = 3;
		end else if (ch[1] == lo) begin
			f = ch[2] - ch[0]; base = 5;
		end else begin
			f = ch[0] - ch[1]; base = 1;
		end
		mag = ((f < 0 ? -f : f) * ONE) / d;
		hue = base * ONE - (f < 0 ? -mag : mag);
		if (hue >= 6 * ONE) hue -= 6 * ONE;
		if (hue < 0) hue = 0;
		sector = hue >>> FRAC_BITS;
		frac = hue & (ONE - 1);
		sat = (d * ONE) / hi;
		if (s > 0) sat += ((ONE - sat) * s) / 256;
		else sat += (sat * s) / 256;
		sat = clip(sat, 0, ONE);
		p = (hi * (ONE - sat)) >>> FRAC_BITS;
		sf = (sat * frac) >>> FRAC_BITS;
		q = (hi * (ONE - sf)) >>> FRAC_BITS;
		sf = (sat * (ONE - frac)) >>> FRAC_BITS;
		t = (hi * (ONE - sf)) >>> FRAC_BITS;
		case (sector)
			0: begin ch[0] = hi; ch[1] = t; ch[2] = p; end
			1: begin ch[0] = q; ch[1] = hi; ch[2] = p; end
			2: begin ch[0] = p; ch[1] = hi; ch[2] = t; end
			3: begin ch[0] = p; ch[1] = q; ch[2] = hi; end
			4: begin ch[0] = t; ch[1] = p; ch[2] = hi; end
			default: begin ch[0] = hi; ch[1] = p; ch[2] = q; end
		endcase
	endfunction

	function automatic pixel_t adjusted_pixel(pixel_t px);
		longint ch[3], b, s, c, factor, total;
		pixel_t r;
		ch[0] = tint_mix(px.red, tint_r);
		ch[1] = tint_mix(px.green, tint_g);
		ch[2] = tint_mix(px.blue, tint_b);
		if (adj_en) begin
			b = longint'($signed(bright_reg));
			s = longint'($signed(sat_reg));
			c = longint'($signed(contrast_reg));
			factor = ((c + 256) * ONE) / (257 - c);
			for (int k = 0; k < 3; k++) ch[k] = clip(ch[k] + b, 1, CH_MAX);
			rescale_saturation(ch, s);
			for (int k = 0; k < 3; k++) begin
				total = (2 * ch[k] - CH_MAX) * factor + CH_MAX * ONE;
				ch[k] = total <= 0 ? 0 : clip(total >>> (FRAC_BITS + 1), 0, CH_MAX);
			end
		end
		r.red = ch[0][7:0]; r.green = ch[1][7:0]; r.blue = ch[2][7:0];
		return r;
	endfunction

	// expected pixels in order of acceptance
	class pixel_scoreboard;
		pixel_t expected_pixels[$];

		function void note_input(pixel_t px);
			expected_pixels.push_back(adjusted_pixel(px));
		endfunction

		function void check_output(pixel_t got);
			pixel_t want;
			if (expected_pixels.size() == 0) begin
				$error("unexpected output pixel %h", got);
				errors++;
				return;
			end
			want = expected_pixels.pop_front();
			if (got.red !== want.red) begin
				$error("red_out expected %0d actual %0d", want.red, got.red);
				errors++;
			end
			if (got.green !== want.green) begin
				$error("green_out expected %0d actual %0d", want.green, got.green);
				errors++;
			end
			if (got.blue !== want.blue) begin
				$error("blue_out expected %0d actual %0d", want.blue, got.blue);
				errors++;
			end
		endfunction
	endclass

	pixel_scoreboard board = new();

	// monitor both streams
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) board.note_input(s_axis_tdata);
		if (arst_n && m_axis_tvalid && m_axis_tready) board.check_output(m_axis_tdata);
	end

	function automatic int gap_len();
		if ($urandom_range(0, 3) == 0) return 0;
		return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
	endfunction

	// receiver with random stalls and a forced hold-off, checked every cycle
	initial begin
		int n;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				m_axis_tready <= 1'b0;
				repeat (80) @(posedge clk);
				hold_off = 1'b0;
			end
			m_axis_tready <= 1'b1;
			n = $urandom_range(1, 12);
			for (int i = 0; i < n && !hold_off; i++) @(posedge clk);
			if (!hold_off) begin
				n = gap_len();
				if (n > 0) begin
					m_axis_tready <= 1'b0;
					for (int i = 0; i < n && !hold_off; i++) @(posedge clk);
				end
			end
		end
	end

	task automatic write_reg(logic [3:0] idx, logic [9:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_TINT_RED:   tint_r = val[7:0];
			CFG_TINT_GREEN: tint_g = val[7:0];
			CFG_TINT_BLUE:  tint_b = val[7:0];
			CFG_BLEND_PCT:  pct_reg = val[6:0];
			CFG_ADJ_EN:     adj_en = val[0];
			CFG_BRIGHT:     bright_reg = val[8:0];
			CFG_SATURATION: sat_reg = val;
			CFG_CONTRAST:   contrast_reg = val[8:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic send_pixel(pixel_t px, bit no_gap);
		int n;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= px;
		do @(posedge clk); while (!s_axis_tready);
		n = no_gap ? 0 : gap_len();
		if (n > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (board.expected_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_all(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [6:0] pct,
			logic en, logic [8:0] br, logic [9:0] sat, logic [8:0] con);
		wait_idle();
		write_reg(CFG_TINT_RED, {2'b0, r});
		write_reg(CFG_TINT_GREEN, {2'b0, g});
		write_reg(CFG_TINT_BLUE, {2'b0, b});
		write_reg(CFG_BLEND_PCT, {3'b0, pct});
		write_reg(CFG_ADJ_EN, {9'b0, en});
		write_reg(CFG_BRIGHT, {1'b0, br});
		write_reg(CFG_SATURATION, sat);
		write_reg(CFG_CONTRAST, {1'b0, con});
	endtask

	function automatic pixel_t rand_pixel();
		pixel_t px;
		px = 24'($urandom);
		// bias toward greys and edge values now and then
		case ($urandom_range(0, 7))
			0: begin px.green = px.red; px.blue = px.red; end
			1: px.red = $urandom_range(0, 1) ? 8'hff : 8'h00;
			2: px.green = px.blue;
			default: ;
		endcase
		return px;
	endfunction

	// stimulus
	initial begin
		pixel_t dir_pixels[$];
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0; s_axis_tdata = '0;
		cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
		tint_r = 0; tint_g = 0; tint_b = 0; pct_reg = 0; adj_en = 0;
		bright_reg = 0; sat_reg = 0; contrast_reg = 0;
		errors = 0; hold_off = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, greys, every hue sector, pass-through after reset
		dir_pixels = '{24'h000000, 24'hffffff, 24'h0000ff, 24'h00ff00, 24'hff0000,
			24'h808080, 24'h00ffff, 24'hff00ff, 24'hffff00, 24'h102030, 24'h302010,
			24'h203010};
		foreach (dir_pixels[i]) send_pixel(dir_pixels[i], 1'b0);
		// adjust on with contrast zero
		write_all(8'd0, 8'd0, 8'd0, 7'd0, 1'b1, 9'd0, 10'd0, 9'd0);
		foreach (dir_pixels[i]) send_pixel(dir_pixels[i], 1'b0);
		// extremes: percent above 100, out-of-range saturation, max contrast
		write_all(8'hff, 8'h00, 8'h80, 7'd127, 1'b1, 9'd255, 10'h1ff, 9'd255);
		foreach (dir_pixels[i]) send_pixel(dir_pixels[i], 1'b0);
		write_all(8'h00, 8'hff, 8'h00, 7'd100, 1'b1, 9'h101, 10'h200, 9'h101);
		foreach (dir_pixels[i]) send_pixel(dir_pixels[i], 1'b0);
		// ignored write to an unused index
		wait_idle();
		write_reg(4'd15, 10'h3ff);

		// random phases
		for (int phase = 0; phase < 8; phase++) begin
			write_all(8'($urandom), 8'($urandom), 8'($urandom),
				7'(($urandom_range(0, 9) == 0) ? $urandom_range(101, 127)
					: $urandom_range(0, 100)),
				phase != 1, 9'($urandom), 10'($urandom), 9'($urandom));
			if (phase == 2) hold_off = 1'b1;
			for (int i = 0; i < 50; i++) send_pixel(rand_pixel(), phase == 2);
			// sender waits for every result once mid-run
			if (phase == 4) wait_idle();
		end

		wait_idle();
		if (errors == 0) $display("testbench: PASS");
		else $display("testbench: FAIL");
		$finish;
	end

	// run limit
	initial begin
		#5ms;
		$display("testbench: FAIL");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl
rtl/cadj_pkg.sv
rtl/color_adjust_pixel_pipeline.sv
rtl/cadj_checker.sv
test/testbench.sv
